### rtl/iol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_pkg
// shared types and constants of the indexed ordered list
// ----------------------------------------------------------------------------
package iol_pkg;

    localparam int CAPACITY_DEF = 16;   // default number of list cells
    localparam int MAX_RESULTS  = 16;   // cap on results of one readout
    localparam int VAL_W        = 32;
    localparam int POS_W        = 5;
    localparam int FPOS_W       = 4;
    localparam int TOT_W        = 5;
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);
    localparam int CMP_W        = 8;    // common width for index compares

    typedef logic signed [VAL_W-1:0] t_value;

    typedef enum logic [2:0] {
        REQ_INSERT_HEAD = 3'd0,
        REQ_INSERT_AT   = 3'd1,
        REQ_DELETE_HEAD = 3'd2,
        REQ_DELETE_AT   = 3'd3,
        REQ_FIND_FIRST  = 3'd4,
        REQ_FIND_ALL    = 3'd5,
        REQ_LIST_ALL    = 3'd6
    } t_req_type;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_BAD_INDEX = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOTHING   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_ROTATE
    } t_cell_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_req_type         req_type;
        logic [POS_W-1:0]  position;
        t_value            item_value;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [FPOS_W-1:0] found_position;
        t_value            element_value;
        logic [TOT_W-1:0]  entry_total;
        logic              last_result;
    } t_rsp;

    // command broadcast along the cell chain
    typedef struct packed {
        t_cell_mode        mode;
        logic [POS_W-1:0]  position;
        t_value            value;
    } t_cell_ctrl;

endpackage

### rtl/iol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_cell
// one list cell: holds an entry and moves it to or from its neighbours
// ----------------------------------------------------------------------------
module iol_cell
    import iol_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_value     i_left,
    input  t_value     i_right,
    output t_value     o_value
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    t_value           r_value;
    t_value           n_value;
    logic [CMP_W-1:0] pos_x;

    assign pos_x = CMP_W'(i_ctrl.position);

    always_comb begin
        n_value = r_value;
        case (i_ctrl.mode)
            CM_INSERT: begin
                if (MY_IDX > pos_x) begin
                    n_value = i_left;
                end else if (MY_IDX == pos_x) begin
                    n_value = i_ctrl.value;
                end
            end
            CM_DELETE: begin
                if (MY_IDX >= pos_x) begin
                    n_value = i_right;
                end
            end
            CM_ROTATE: n_value = i_right;
            default:   n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### rtl/iol_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_chain
// ring of list cells, head entry at cell zero
// ----------------------------------------------------------------------------
module iol_chain
    import iol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    output t_value     o_head
);

    t_value cell_val [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? CAPACITY - 1 : g - 1;
        localparam int RIGHT = (g == CAPACITY - 1) ? 0 : g + 1;
        iol_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_left  (cell_val[LEFT]),
            .i_right (cell_val[RIGHT]),
            .o_value (cell_val[g])
        );
    end

    assign o_head = cell_val[0];

endmodule

### rtl/indexed_ordered_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_top
// ordered list of signed 32-bit entries held in a ring of cells
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, position 0 in cell 0. Insert
// and delete requests shift every affected cell at once and give one
// response. find_first, find_all and list_all rotate the ring one place a
// cycle past cell 0, while the response register is free to move; cell 0
// compares or lists the entry there. A full turn puts the ring back, and a
// flush state then sends the final response. A new request is taken when
// the block is idle and its response register is empty or being read in
// that cycle. Every response carries the entry count after the request; the
// last response of a request has last_result set, and readouts stop after
// MAX_RESULTS responses.
// ----------------------------------------------------------------------------
module indexed_ordered_list_top
    import iol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_k, n_k;           // scan step, entry now in cell 0
    logic [RES_W-1:0]   r_n, n_n;           // responses found so far
    t_req_type          r_type, n_type;
    t_value             r_val, n_val;
    // one held-back hit, so that the last one can be marked
    logic               r_pend_valid, n_pend_valid;
    logic [FPOS_W-1:0]  r_pend_pos, n_pend_pos;
    t_value             r_pend_val, n_pend_val;
    // response register
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    t_cell_ctrl         cell_ctrl;
    t_value             head;
    logic               slot_free;
    logic               req_acc;
    logic               is_scan;
    logic               scan_end;
    logic               hit;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cnt_x;

    iol_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctrl (cell_ctrl),
        .o_head (head)
    );

    assign slot_free   = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == ST_IDLE) && slot_free;
    assign req_acc     = i_req_valid && o_req_ready;
    assign is_scan     = (i_req.req_type == REQ_FIND_FIRST) ||
                         (i_req.req_type == REQ_FIND_ALL) ||
                         (i_req.req_type == REQ_LIST_ALL);
    assign scan_end    = (r_k == IDX_W'(CAPACITY - 1));
    assign pos_x       = CMP_W'(i_req.position);
    assign cnt_x       = CMP_W'(r_count);

    // entry in cell 0 is live, matches (any entry for list_all) and the response cap is not reached
    always_comb begin
        hit = (CMP_W'(r_k) < cnt_x) && (r_n < RES_W'(MAX_RESULTS));
        if (r_type != REQ_LIST_ALL) begin
            hit = hit && (head == r_val);
        end
        if (r_type == REQ_FIND_FIRST) begin
            hit = hit && (r_n == '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc && is_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (slot_free && scan_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_k          = r_k;
        n_n          = r_n;
        n_type       = r_type;
        n_val        = r_val;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_pend_val   = r_pend_val;
        n_out_valid  = r_out_valid && !i_rsp_ready;
        n_out        = r_out;
        cell_ctrl.mode     = CM_HOLD;
        cell_ctrl.position = i_req.position;
        cell_ctrl.value    = i_req.item_value;

        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_out.status         = STS_OK;
                    n_out.found_position = '0;
                    n_out.element_value  = i_req.item_value;
                    n_out.last_result    = 1'b1;
                    case (i_req.req_type)
                        REQ_INSERT_HEAD, REQ_INSERT_AT: begin
                            if (i_req.req_type == REQ_INSERT_HEAD) begin
                                cell_ctrl.position = '0;
                            end
                            if ((i_req.req_type == REQ_INSERT_AT) && (pos_x > cnt_x)) begin
                                n_out.status = STS_BAD_INDEX;
                            end else if (cnt_x >= CMP_W'(CAPACITY)) begin
                                n_out.status = STS_FULL;
                            end else begin
                                cell_ctrl.mode = CM_INSERT;
                                n_count        = r_count + 1'b1;
                                if (i_req.req_type == REQ_INSERT_AT) begin
                                    n_out.found_position = FPOS_W'(i_req.position);
                                end
                            end
                        end
                        REQ_DELETE_HEAD: begin
                            cell_ctrl.position = '0;
                            if (r_count == '0) begin
                                n_out.status = STS_NOTHING;
                            end else begin
                                cell_ctrl.mode = CM_DELETE;
                                n_count        = r_count - 1'b1;
                            end
                        end
                        REQ_DELETE_AT: begin
                            if (pos_x >= cnt_x) begin
                                n_out.status = STS_BAD_INDEX;
                            end else begin
                                cell_ctrl.mode       = CM_DELETE;
                                n_count              = r_count - 1'b1;
                                n_out.found_position = FPOS_W'(i_req.position);
                            end
                        end
                        REQ_FIND_FIRST, REQ_FIND_ALL, REQ_LIST_ALL: begin
                            n_type       = i_req.req_type;
                            n_val        = i_req.item_value;
                            n_k          = '0;
                            n_n          = '0;
                            n_pend_valid = 1'b0;
                        end
                        default: n_out.status = STS_NOTHING;   // unused request code
                    endcase
                    n_out.entry_total = TOT_W'(n_count);
                    n_out_valid       = !is_scan;
                end
            end
            ST_SCAN: begin
                if (slot_free) begin
                    cell_ctrl.mode = CM_ROTATE;
                    n_k            = r_k + 1'b1;
                    if (hit) begin
                        // earlier hit is not the last one, send it now
                        if (r_pend_valid) begin
                            n_out_valid          = 1'b1;
                            n_out.status         = STS_OK;
                            n_out.found_position = r_pend_pos;
                            n_out.element_value  = r_pend_val;
                            n_out.entry_total    = TOT_W'(r_count);
                            n_out.last_result    = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_pos   = FPOS_W'(r_k);
                        n_pend_val   = head;
                        n_n          = r_n + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out.entry_total = TOT_W'(r_count);
                    n_out.last_result = 1'b1;
                    if (r_pend_valid) begin
                        n_out.status         = STS_OK;
                        n_out.found_position = r_pend_pos;
                        n_out.element_value  = r_pend_val;
                    end else begin
                        n_out.status         = STS_NOTHING;
                        n_out.found_position = '0;
                        n_out.element_value  = (r_type == REQ_LIST_ALL) ? '0 : r_val;
                    end
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_n        <= n_n;
        r_type     <= n_type;
        r_val      <= n_val;
        r_pend_pos <= n_pend_pos;
        r_pend_val <= n_pend_val;
        r_out      <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

### rtl/iol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iol_checker
// port-level checks of the indexed ordered list
// ----------------------------------------------------------------------------
module iol_checker
    import iol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // stalled response stays up
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid)
        else $error("response dropped while stalled");

    // stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> $stable(o_rsp))
        else $error("response changed while stalled");

    // failures are single responses reporting position zero
    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != STS_OK) |->
            (o_rsp.last_result && (o_rsp.found_position == '0)))
        else $error("failed request with more than one response or a position");

    // a request is only taken when the response register can move
    a_req_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |-> (!o_rsp_valid || i_rsp_ready))
        else $error("request taken while a response is stalled");

    // count never passes the capacity
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (32'(o_rsp.entry_total) <= CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind indexed_ordered_list_top iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the indexed ordered list
// ----------------------------------------------------------------------------
// A shadow copy of the list is kept in a queue and updated as each request is
// taken. The responses that request should give are queued, and every
// response the block hands out is checked field by field against the oldest
// one queued. Directed requests cover the empty list, the extreme values and
// every failure status. The random part then runs fill, mix and
// drain sequences. Both handshake sides insert random gaps.
// ----------------------------------------------------------------------------
module tb;
    import iol_pkg::*;

    localparam int          LIST_CAP        = CAPACITY_DEF;
    localparam logic [2:0]  REQ_CODE_UNUSED = 3'd7;       // not decoded by the block
    localparam int          MAX_GAP         = 13;
    localparam int          STALL_LIMIT     = 2000;       // cycles with no handshake
    localparam int          REPORT_LIMIT    = 10;
    localparam int          RANDOM_ITEMS    = 110;

    localparam t_value VAL_MAX  = 32'sh7fff_ffff;
    localparam t_value VAL_MIN  = 32'sh8000_0000;
    localparam t_value VAL_ONES = -32'sd1;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    t_req req_bus   = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // shadow of the list contents, position 0 at the front
    t_value shadow_entries[$];
    // responses still owed by the block, oldest first
    t_rsp   owed_responses[$];

    t_value value_pool[4];
    int     mismatch_count  = 0;
    int     req_quiet_left  = 0;
    int     rsp_quiet_left  = 0;
    int     idle_cycles     = 0;

    indexed_ordered_list_top #(
        .CAPACITY    (LIST_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req_bus),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // shadow list and expected responses
    // ------------------------------------------------------------------

    // every response carries the entry count after the request
    function automatic void owe_response(t_status st, int pos, t_value val, bit last);
        t_rsp rsp;
        rsp.status         = st;
        rsp.found_position = FPOS_W'(pos);
        rsp.element_value  = val;
        rsp.entry_total    = TOT_W'(shadow_entries.size());
        rsp.last_result    = last;
        owed_responses.push_back(rsp);
    endfunction

    // index check comes before the capacity check
    function automatic t_status shadow_insert(int pos, t_value val);
        if (pos > shadow_entries.size())
            return STS_BAD_INDEX;
        if (shadow_entries.size() >= LIST_CAP)
            return STS_FULL;
        shadow_entries.insert(pos, val);
        return STS_OK;
    endfunction

    function automatic t_status shadow_delete(int pos);
        if (pos >= shadow_entries.size())
            return STS_BAD_INDEX;
        shadow_entries.delete(pos);
        return STS_OK;
    endfunction

    // apply one accepted request to the shadow list and queue what it owes
    function automatic void predict_list_request(t_req req);
        t_status st;
        int      pos;
        int      hits[$];
        pos = int'(req.position);
        case (req.req_type)
            REQ_INSERT_HEAD: begin
                st = shadow_insert(0, req.item_value);
                owe_response(st, 0, req.item_value, 1'b1);
            end
            REQ_INSERT_AT: begin
                st = shadow_insert(pos, req.item_value);
                owe_response(st, (st == STS_OK) ? pos : 0, req.item_value, 1'b1);
            end
            REQ_DELETE_HEAD: begin
                st = (shadow_entries.size() == 0) ? STS_NOTHING : shadow_delete(0);
                owe_response(st, 0, req.item_value, 1'b1);
            end
            REQ_DELETE_AT: begin
                st = shadow_delete(pos);
                owe_response(st, (st == STS_OK) ? pos : 0, req.item_value, 1'b1);
            end
            REQ_FIND_FIRST, REQ_FIND_ALL: begin
                foreach (shadow_entries[i])
                    if (shadow_entries[i] == req.item_value && hits.size() < MAX_RESULTS)
                        hits.push_back(i);
                if (hits.size() == 0)
                    owe_response(STS_NOTHING, 0, req.item_value, 1'b1);
                else if (req.req_type == REQ_FIND_FIRST)
                    owe_response(STS_OK, hits[0], req.item_value, 1'b1);
                else
                    foreach (hits[k])
                        owe_response(STS_OK, hits[k], req.item_value,
                                     k == hits.size() - 1);
            end
            REQ_LIST_ALL: begin
                if (shadow_entries.size() == 0)
                    owe_response(STS_NOTHING, 0, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_entries.size() && i < MAX_RESULTS; i++)
                        owe_response(STS_OK, i, shadow_entries[i],
                                     i == shadow_entries.size() - 1 || i == MAX_RESULTS - 1);
            end
            default: begin
                // unused request code: ignored apart from its one response
                owe_response(STS_NOTHING, 0, req.item_value, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // random idle gap, with the odd run of back-to-back items
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic t_req make_req(t_req_type kind, int pos, t_value val);
        t_req req;
        req.req_type   = kind;
        req.position   = POS_W'(pos);
        req.item_value = val;
        return req;
    endfunction

    // mostly values that repeat, so that searches hit, plus extremes and noise
    function automatic t_value pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return value_pool[$urandom_range(0, 3)];
        if (sel < 75) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return '0;
                default: return VAL_ONES;
            endcase
        end
        return t_value'($urandom);
    endfunction

    // mostly near the valid range, now and then any 5-bit position
    function automatic int pick_position();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, shadow_entries.size() + 1);
        return $urandom_range(0, (1 << POS_W) - 1);
    endfunction

    // called at a clock edge; returns at the edge where the request is taken,
    // leaving valid high so that a back-to-back request needs no toggle
    task automatic send_request(input t_req req);
        int gap;
        gap = draw_gap(req_quiet_left);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_bus   <= req;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        predict_list_request(req);
    endtask

    task automatic idle_request_port();
        req_valid <= 1'b0;
    endtask

    // sender holds off until every owed response is in
    task automatic wait_until_drained();
        idle_request_port();
        while (owed_responses.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every failure status that an empty list can give
    task automatic test_empty_list();
        send_request(make_req(REQ_LIST_ALL, 0, VAL_ONES));
        send_request(make_req(REQ_FIND_FIRST, 0, value_pool[0]));
        send_request(make_req(REQ_FIND_ALL, 3, value_pool[0]));
        send_request(make_req(REQ_DELETE_HEAD, 0, VAL_MAX));
        send_request(make_req(REQ_DELETE_AT, 0, VAL_MIN));
        send_request(make_req(REQ_INSERT_AT, 1, value_pool[1]));
        send_request(make_req(t_req_type'(REQ_CODE_UNUSED), 31, VAL_ONES));
    endtask

    // extreme values and positions on a short list
    task automatic test_edge_values();
        send_request(make_req(REQ_INSERT_HEAD, 31, VAL_MAX));
        send_request(make_req(REQ_INSERT_AT, 1, VAL_MIN));
        send_request(make_req(REQ_INSERT_AT, 2, '0));
        send_request(make_req(REQ_INSERT_AT, 3, VAL_ONES));
        send_request(make_req(REQ_INSERT_AT, 31, VAL_MAX));
        send_request(make_req(REQ_INSERT_AT, 5, VAL_MAX));
        send_request(make_req(REQ_FIND_FIRST, 0, VAL_MIN));
        send_request(make_req(REQ_INSERT_HEAD, 0, VAL_MIN));
        send_request(make_req(REQ_FIND_ALL, 0, VAL_MIN));
        send_request(make_req(REQ_LIST_ALL, 0, VAL_MAX));
        send_request(make_req(REQ_DELETE_AT, 4, '0));
        send_request(make_req(REQ_DELETE_AT, 4, '0));
        send_request(make_req(REQ_DELETE_AT, 31, '0));
        send_request(make_req(REQ_DELETE_HEAD, 16, VAL_ONES));
        send_request(make_req(t_req_type'(REQ_CODE_UNUSED), 0, VAL_MIN));
    endtask

    // remove entries at random until empty, then hit the empty cases again
    task automatic test_drain_list();
        while (shadow_entries.size() > 0) begin
            case ($urandom_range(0, 5))
                0, 1:    send_request(make_req(REQ_DELETE_HEAD, pick_position(), pick_value()));
                2:       send_request(make_req(REQ_LIST_ALL, pick_position(), pick_value()));
                default: send_request(make_req(REQ_DELETE_AT,
                                                $urandom_range(0, shadow_entries.size() - 1),
                                                pick_value()));
            endcase
        end
        send_request(make_req(REQ_DELETE_HEAD, 0, pick_value()));
        send_request(make_req(REQ_DELETE_AT, 0, pick_value()));
    endtask

    // fill with one value so find_all returns a full set, then probe the bound
    task automatic test_fill_to_capacity();
        t_value fill_val;
        fill_val = pick_value();
        while (shadow_entries.size() < LIST_CAP)
            send_request(make_req(REQ_INSERT_AT, $urandom_range(0, shadow_entries.size()),
                                  fill_val));
        send_request(make_req(REQ_INSERT_HEAD, 0, pick_value()));
        send_request(make_req(REQ_INSERT_AT, LIST_CAP, pick_value()));
        send_request(make_req(REQ_INSERT_AT, LIST_CAP + 1, pick_value()));
        send_request(make_req(REQ_INSERT_AT, $urandom_range(LIST_CAP + 2, 31), pick_value()));
        send_request(make_req(REQ_FIND_ALL, 0, fill_val));
        send_request(make_req(REQ_FIND_FIRST, 0, ~fill_val));
        send_request(make_req(REQ_LIST_ALL, 0, pick_value()));
        send_request(make_req(REQ_DELETE_AT, LIST_CAP, pick_value()));
        send_request(make_req(REQ_DELETE_AT, LIST_CAP - 1, pick_value()));
        send_request(make_req(REQ_INSERT_AT, LIST_CAP - 1, ~fill_val));
        send_request(make_req(REQ_FIND_FIRST, 0, ~fill_val));
    endtask

    // alternating growth and shrink phases so the list sweeps its whole range
    task automatic test_random_mix();
        int     sel;
        bit     growing;
        t_req   req;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0)
                growing = ((n / 30) % 2 == 0);
            sel = $urandom_range(0, 99);
            if (sel < (growing ? 35 : 12))
                req = make_req(REQ_INSERT_HEAD, pick_position(), pick_value());
            else if (sel < (growing ? 60 : 25))
                req = make_req(REQ_INSERT_AT, pick_position(), pick_value());
            else if (sel < 45)
                req = make_req(REQ_DELETE_HEAD, pick_position(), pick_value());
            else if (sel < 65)
                req = make_req(REQ_DELETE_AT, pick_position(), pick_value());
            else if (sel < 78)
                req = make_req(REQ_FIND_FIRST, pick_position(), pick_value());
            else if (sel < 88)
                req = make_req(REQ_FIND_ALL, pick_position(), pick_value());
            else if (sel < 96)
                req = make_req(REQ_LIST_ALL, pick_position(), pick_value());
            else
                req = make_req(t_req_type'(REQ_CODE_UNUSED), pick_position(), pick_value());
            send_request(req);
        end
    endtask

    // ------------------------------------------------------------------
    // response side: random stall before each response is taken
    // ------------------------------------------------------------------
    initial begin : rsp_stall
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(rsp_quiet_left);
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_rsp_valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // response checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t unexpected response: status %0d pos %0d value %0d",
                             $realtime, o_rsp.status, o_rsp.found_position,
                             o_rsp.element_value,
                             " total %0d last %0d",
                             o_rsp.entry_total, o_rsp.last_result);
            end else begin
                want = owed_responses.pop_front();
                if (o_rsp.status         !== want.status         ||
                    o_rsp.found_position !== want.found_position ||
                    o_rsp.element_value  !== want.element_value  ||
                    o_rsp.entry_total    !== want.entry_total    ||
                    o_rsp.last_result    !== want.last_result) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t response differs: expected status %0d pos %0d",
                                 $realtime, want.status, want.found_position,
                                 " value %0d total %0d last %0d,",
                                 want.element_value, want.entry_total, want.last_result,
                                 " got status %0d pos %0d value %0d",
                                 o_rsp.status, o_rsp.found_position, o_rsp.element_value,
                                 " total %0d last %0d",
                                 o_rsp.entry_total, o_rsp.last_result);
                end
            end
        end
    end

    // watchdog: too long without any handshake means the block has hung
    always @(posedge i_clk) begin
        if ((req_valid && o_req_ready) || (o_rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("indexed_ordered_list_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (value_pool[i])
            value_pool[i] = t_value'($urandom);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edge_values();
        wait_until_drained();
        test_drain_list();
        test_fill_to_capacity();
        test_random_mix();
        wait_until_drained();
        test_fill_to_capacity();
        test_drain_list();

        // let any stray response surface before the verdict
        wait_until_drained();
        repeat (LIST_CAP + 20) @(posedge i_clk);

        if (mismatch_count == 0 && owed_responses.size() == 0)
            $display("indexed_ordered_list_top: match");
        else
            $display("indexed_ordered_list_top: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/iol_pkg.sv
rtl/iol_cell.sv
rtl/iol_chain.sv
rtl/indexed_ordered_list_top.sv
rtl/iol_checker.sv
bench/tb.sv
